FILE: rtl/lookat_pkg.sv
package lookat_pkg;

  localparam int NUM_AXES = 3;
  localparam int W_COORD  = 32;
  localparam int W_UNIT   = 18;
  localparam int W_DIFF   = 33;
  localparam int W_CROSS  = 51;
  localparam int W_MAG    = 31;
  localparam int W_RAD    = 64;
  localparam int W_LEN    = 32;
  localparam int W_QUO    = 17;
  localparam int W_REM    = 48;
  localparam int W_ACC    = 52;
  localparam int W_RND    = 36;
  localparam int FRAC     = 16;
  localparam int SCALE_MSB = 30;
  localparam logic signed [W_UNIT-1:0] Q_ONE = 18'sd65536;

  // round a q16-scaled sum to integer, halves away from zero
  function automatic logic signed [W_RND-1:0] round16(input logic signed [W_ACC-1:0] v);
    logic [W_ACC-1:0] mag;
    logic [W_ACC-1:0] sh;
    mag = v[W_ACC-1] ? W_ACC'(-v) : W_ACC'(v);
    sh  = (mag + W_ACC'(32768)) >> FRAC;
    return v[W_ACC-1] ? -$signed(sh[W_RND-1:0]) : $signed(sh[W_RND-1:0]);
  endfunction

  // clamp to [-1, 1] in q1.16
  function automatic logic signed [W_UNIT-1:0] clamp_unit(input logic signed [W_RND-1:0] v);
    if (v > W_RND'(Q_ONE)) return Q_ONE;
    if (v < -W_RND'(Q_ONE)) return -Q_ONE;
    return v[W_UNIT-1:0];
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [W_COORD-1:0] sat32(input logic signed [W_RND-1:0] v);
    if (v > W_RND'(33'sh0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -W_RND'(33'sh0_8000_0000)) return 32'sh8000_0000;
    return v[W_COORD-1:0];
  endfunction

endpackage

FILE: rtl/look_at_view_matrix_core.sv
// throughput: one transaction per cycle; the whole pipeline holds while a result
//   waits under out_stall, so in_stall follows that condition
// depth is set by the two normalize units: a 32-stage square root and a
//   17-stage divider each
// reset: rst clears the valid bit of every stage; data registers are not reset
module look_at_view_matrix_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lookat_pkg::W_COORD-1:0] eye_x,
  input  logic signed [lookat_pkg::W_COORD-1:0] eye_y,
  input  logic signed [lookat_pkg::W_COORD-1:0] eye_z,
  input  logic signed [lookat_pkg::W_COORD-1:0] target_x,
  input  logic signed [lookat_pkg::W_COORD-1:0] target_y,
  input  logic signed [lookat_pkg::W_COORD-1:0] target_z,
  input  logic signed [lookat_pkg::W_COORD-1:0] up_x,
  input  logic signed [lookat_pkg::W_COORD-1:0] up_y,
  input  logic signed [lookat_pkg::W_COORD-1:0] up_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lookat_pkg::W_UNIT-1:0]  side_x,
  output logic signed [lookat_pkg::W_UNIT-1:0]  side_y,
  output logic signed [lookat_pkg::W_UNIT-1:0]  side_z,
  output logic signed [lookat_pkg::W_UNIT-1:0]  true_up_x,
  output logic signed [lookat_pkg::W_UNIT-1:0]  true_up_y,
  output logic signed [lookat_pkg::W_UNIT-1:0]  true_up_z,
  output logic signed [lookat_pkg::W_UNIT-1:0]  back_x,
  output logic signed [lookat_pkg::W_UNIT-1:0]  back_y,
  output logic signed [lookat_pkg::W_UNIT-1:0]  back_z,
  output logic signed [lookat_pkg::W_COORD-1:0] side_offset,
  output logic signed [lookat_pkg::W_COORD-1:0] up_offset,
  output logic signed [lookat_pkg::W_COORD-1:0] fwd_offset
);
  import lookat_pkg::*;

  localparam int VEC_W = NUM_AXES * W_COORD;
  localparam int UV_W  = NUM_AXES * W_UNIT;
  localparam int W_P   = W_UNIT + W_COORD;
  localparam int W_SF  = 2 * W_UNIT;

  typedef logic signed [W_COORD-1:0] coord_t;
  typedef logic signed [W_UNIT-1:0]  unit_t;

  logic en;

  // global advance: hold everything while a result is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage t0: target minus eye
  logic                            t0_valid;
  logic [NUM_AXES-1:0][W_DIFF-1:0] t0_d;
  coord_t                          t0_eye [NUM_AXES];
  coord_t                          t0_up  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= W_DIFF'(target_x) - W_DIFF'(eye_x);
      t0_d[1] <= W_DIFF'(target_y) - W_DIFF'(eye_y);
      t0_d[2] <= W_DIFF'(target_z) - W_DIFF'(eye_z);
      t0_eye  <= '{eye_x, eye_y, eye_z};
      t0_up   <= '{up_x, up_y, up_z};
    end
  end

  // forward vector
  logic                            n1_valid;
  logic [NUM_AXES-1:0][W_UNIT-1:0] n1_f;
  logic [2*VEC_W-1:0]              n1_sb;

  lookat_norm #(.IN_W(W_DIFF), .SB_W(2 * VEC_W)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t0_valid),
    .vec      (t0_d),
    .sb_in    ({t0_eye[0], t0_eye[1], t0_eye[2], t0_up[0], t0_up[1], t0_up[2]}),
    .out_valid(n1_valid),
    .unit     (n1_f),
    .sb_out   (n1_sb)
  );

  coord_t n1_eye [NUM_AXES];
  coord_t n1_up  [NUM_AXES];
  unit_t  n1_fs  [NUM_AXES];

  assign {n1_eye[0], n1_eye[1], n1_eye[2], n1_up[0], n1_up[1], n1_up[2]} = n1_sb;
  assign n1_fs = '{n1_f[0], n1_f[1], n1_f[2]};

  // stage t1: cross products of forward and up
  logic                     t1_valid;
  logic signed [W_P-1:0]    t1_p [6];
  coord_t                   t1_eye [NUM_AXES];
  unit_t                    t1_f   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      t1_p[0] <= W_P'(n1_fs[1]) * W_P'(n1_up[2]);
      t1_p[1] <= W_P'(n1_fs[2]) * W_P'(n1_up[1]);
      t1_p[2] <= W_P'(n1_fs[2]) * W_P'(n1_up[0]);
      t1_p[3] <= W_P'(n1_fs[0]) * W_P'(n1_up[2]);
      t1_p[4] <= W_P'(n1_fs[0]) * W_P'(n1_up[1]);
      t1_p[5] <= W_P'(n1_fs[1]) * W_P'(n1_up[0]);
      t1_eye  <= n1_eye;
      t1_f    <= n1_fs;
    end
  end

  // stage t2: cross differences
  logic                             t2_valid;
  logic [NUM_AXES-1:0][W_CROSS-1:0] t2_c;
  coord_t                           t2_eye [NUM_AXES];
  unit_t                            t2_f   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      t2_c[0] <= W_CROSS'(t1_p[0]) - W_CROSS'(t1_p[1]);
      t2_c[1] <= W_CROSS'(t1_p[2]) - W_CROSS'(t1_p[3]);
      t2_c[2] <= W_CROSS'(t1_p[4]) - W_CROSS'(t1_p[5]);
      t2_eye  <= t1_eye;
      t2_f    <= t1_f;
    end
  end

  // side vector
  logic                            n2_valid;
  logic [NUM_AXES-1:0][W_UNIT-1:0] n2_s;
  logic [VEC_W+UV_W-1:0]           n2_sb;

  lookat_norm #(.IN_W(W_CROSS), .SB_W(VEC_W + UV_W)) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t2_valid),
    .vec      (t2_c),
    .sb_in    ({t2_eye[0], t2_eye[1], t2_eye[2], t2_f[0], t2_f[1], t2_f[2]}),
    .out_valid(n2_valid),
    .unit     (n2_s),
    .sb_out   (n2_sb)
  );

  coord_t n2_eye [NUM_AXES];
  unit_t  n2_f   [NUM_AXES];
  unit_t  n2_ss  [NUM_AXES];

  assign {n2_eye[0], n2_eye[1], n2_eye[2], n2_f[0], n2_f[1], n2_f[2]} = n2_sb;
  assign n2_ss = '{n2_s[0], n2_s[1], n2_s[2]};

  // stage t3: products for true up and the side and forward dots
  logic                   t3_valid;
  logic signed [W_SF-1:0] t3_sf [6];
  logic signed [W_P-1:0]  t3_se [NUM_AXES];
  logic signed [W_P-1:0]  t3_fe [NUM_AXES];
  coord_t                 t3_eye [NUM_AXES];
  unit_t                  t3_s   [NUM_AXES];
  unit_t                  t3_f   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      t3_sf[0] <= W_SF'(n2_ss[1]) * W_SF'(n2_f[2]);
      t3_sf[1] <= W_SF'(n2_ss[2]) * W_SF'(n2_f[1]);
      t3_sf[2] <= W_SF'(n2_ss[2]) * W_SF'(n2_f[0]);
      t3_sf[3] <= W_SF'(n2_ss[0]) * W_SF'(n2_f[2]);
      t3_sf[4] <= W_SF'(n2_ss[0]) * W_SF'(n2_f[1]);
      t3_sf[5] <= W_SF'(n2_ss[1]) * W_SF'(n2_f[0]);
      for (int k = 0; k < NUM_AXES; k++) begin
        t3_se[k] <= W_P'(n2_ss[k]) * W_P'(n2_eye[k]);
        t3_fe[k] <= W_P'(n2_f[k]) * W_P'(n2_eye[k]);
      end
      t3_eye <= n2_eye;
      t3_s   <= n2_ss;
      t3_f   <= n2_f;
    end
  end

  // stage t4: true up differences and dot sums
  logic                     t4_valid;
  logic signed [W_ACC-1:0]  t4_ud [NUM_AXES];
  logic signed [W_ACC-1:0]  t4_sdot;
  logic signed [W_ACC-1:0]  t4_fdot;
  coord_t                   t4_eye [NUM_AXES];
  unit_t                    t4_s   [NUM_AXES];
  unit_t                    t4_f   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      t4_ud[0] <= W_ACC'(t3_sf[0]) - W_ACC'(t3_sf[1]);
      t4_ud[1] <= W_ACC'(t3_sf[2]) - W_ACC'(t3_sf[3]);
      t4_ud[2] <= W_ACC'(t3_sf[4]) - W_ACC'(t3_sf[5]);
      t4_sdot  <= W_ACC'(t3_se[0]) + W_ACC'(t3_se[1]) + W_ACC'(t3_se[2]);
      t4_fdot  <= W_ACC'(t3_fe[0]) + W_ACC'(t3_fe[1]) + W_ACC'(t3_fe[2]);
      t4_eye   <= t3_eye;
      t4_s     <= t3_s;
      t4_f     <= t3_f;
    end
  end

  // stage t5: round true up, finish side and forward offsets
  logic    t5_valid;
  unit_t   t5_u [NUM_AXES];
  coord_t  t5_soff;
  coord_t  t5_foff;
  coord_t  t5_eye [NUM_AXES];
  unit_t   t5_s   [NUM_AXES];
  unit_t   t5_f   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        t5_u[k] <= clamp_unit(round16(t4_ud[k]));
      end
      t5_soff <= sat32(-round16(t4_sdot));
      t5_foff <= sat32(round16(t4_fdot));
      t5_eye  <= t4_eye;
      t5_s    <= t4_s;
      t5_f    <= t4_f;
    end
  end

  // stage t6: true up times eye
  logic                  t6_valid;
  logic signed [W_P-1:0] t6_ue [NUM_AXES];
  unit_t                 t6_u [NUM_AXES];
  unit_t                 t6_s [NUM_AXES];
  unit_t                 t6_f [NUM_AXES];
  coord_t                t6_soff;
  coord_t                t6_foff;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        t6_ue[k] <= W_P'(t5_u[k]) * W_P'(t5_eye[k]);
      end
      t6_u    <= t5_u;
      t6_s    <= t5_s;
      t6_f    <= t5_f;
      t6_soff <= t5_soff;
      t6_foff <= t5_foff;
    end
  end

  // stage t7: true up dot sum
  logic                    t7_valid;
  logic signed [W_ACC-1:0] t7_udot;
  unit_t                   t7_u [NUM_AXES];
  unit_t                   t7_s [NUM_AXES];
  unit_t                   t7_f [NUM_AXES];
  coord_t                  t7_soff;
  coord_t                  t7_foff;

  always_ff @(posedge clk) begin
    if (en) begin
      t7_udot <= W_ACC'(t6_ue[0]) + W_ACC'(t6_ue[1]) + W_ACC'(t6_ue[2]);
      t7_u    <= t6_u;
      t7_s    <= t6_s;
      t7_f    <= t6_f;
      t7_soff <= t6_soff;
      t7_foff <= t6_foff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      side_x      <= t7_s[0];
      side_y      <= t7_s[1];
      side_z      <= t7_s[2];
      true_up_x   <= t7_u[0];
      true_up_y   <= t7_u[1];
      true_up_z   <= t7_u[2];
      back_x      <= -t7_f[0];
      back_y      <= -t7_f[1];
      back_z      <= -t7_f[2];
      side_offset <= t7_soff;
      up_offset   <= sat32(-round16(t7_udot));
      fwd_offset  <= t7_foff;
    end
  end

  // valid bits for the top-level stages
  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid  <= 1'b0;
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      t3_valid  <= 1'b0;
      t4_valid  <= 1'b0;
      t5_valid  <= 1'b0;
      t6_valid  <= 1'b0;
      t7_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      t0_valid  <= in_valid;
      t1_valid  <= n1_valid;
      t2_valid  <= t1_valid;
      t3_valid  <= n2_valid;
      t4_valid  <= t3_valid;
      t5_valid  <= t4_valid;
      t6_valid  <= t5_valid;
      t7_valid  <= t6_valid;
      out_valid <= t7_valid;
    end
  end

`ifndef SYNTH
  // an accepted transaction lands in the first stage
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> t0_valid)
    else $error("accepted transaction not captured");

  // x components of the rotation entries stay within one
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (side_x <= Q_ONE && side_x >= -Q_ONE &&
                   true_up_x <= Q_ONE && true_up_x >= -Q_ONE &&
                   back_x <= Q_ONE && back_x >= -Q_ONE))
    else $error("rotation entry out of range");

  // zero forward vector gives zero forward offset
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && back_x == '0 && back_y == '0 && back_z == '0) |-> fwd_offset == '0)
    else $error("forward offset nonzero for zero forward vector");

  // zero side vector gives zero true up and zero side and up offsets
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && side_x == '0 && side_y == '0 && side_z == '0) |->
      (true_up_x == '0 && true_up_y == '0 && true_up_z == '0 &&
       side_offset == '0 && up_offset == '0))
    else $error("nonzero true up for zero side vector");
`endif

endmodule

FILE: rtl/lookat_sqrt.sv
module lookat_sqrt #(
  parameter int SB_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [lookat_pkg::W_RAD-1:0] rad,
  input  logic [SB_W-1:0]             sb_in,
  output logic                        out_valid,
  output logic [lookat_pkg::W_LEN-1:0] root,
  output logic [SB_W-1:0]             sb_out
);
  import lookat_pkg::*;

  logic [W_RAD-1:0] rem_r  [W_LEN];
  logic [W_LEN-1:0] root_r [W_LEN];
  logic [SB_W-1:0]  sb_r   [W_LEN];
  logic             vld_r  [W_LEN];

  // one root bit per stage, most significant first
  for (genvar i = 0; i < W_LEN; i++) begin : g_stage
    localparam int B = W_LEN - 1 - i;
    logic [W_RAD-1:0] rem_in;
    logic [W_LEN-1:0] root_in;
    logic [SB_W-1:0]  sb_s;
    logic             v_in;
    logic [W_RAD+1:0] trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
      assign sb_s    = sb_in;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sb_s    = sb_r[i-1];
      assign v_in    = vld_r[i-1];
    end

    assign trial = ({{(W_RAD+2-W_LEN){1'b0}}, root_in} << (B + 1))
                 + ({{(W_RAD+1){1'b0}}, 1'b1} << (2 * B));
    assign ge = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? rem_in - trial[W_RAD-1:0] : rem_in;
        root_r[i] <= ge ? (root_in | (W_LEN'(1) << B)) : root_in;
        sb_r[i]   <= sb_s;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end
  end

  assign out_valid = vld_r[W_LEN-1];
  assign root      = root_r[W_LEN-1];
  assign sb_out    = sb_r[W_LEN-1];

endmodule

FILE: rtl/lookat_div.sv
module lookat_div #(
  parameter int SB_W = 1
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  logic                                                    in_valid,
  input  logic [lookat_pkg::NUM_AXES-1:0][lookat_pkg::W_MAG-1:0] mag,
  input  logic [lookat_pkg::W_LEN-1:0]                           len,
  input  logic [SB_W-1:0]                                        sb_in,
  output logic                                                    out_valid,
  output logic [lookat_pkg::NUM_AXES-1:0][lookat_pkg::W_QUO-1:0] quo,
  output logic [SB_W-1:0]                                        sb_out
);
  import lookat_pkg::*;

  logic [NUM_AXES-1:0][W_REM-1:0] rem_r [W_QUO];
  logic [NUM_AXES-1:0][W_QUO-1:0] quo_r [W_QUO];
  logic [W_LEN-1:0]               len_r [W_QUO];
  logic [SB_W-1:0]                sb_r  [W_QUO];
  logic                           vld_r [W_QUO];

  // restoring divide, one quotient bit per stage on three lanes
  for (genvar i = 0; i < W_QUO; i++) begin : g_stage
    localparam int B = W_QUO - 1 - i;
    logic [NUM_AXES-1:0][W_REM-1:0] rem_in;
    logic [NUM_AXES-1:0][W_QUO-1:0] quo_in;
    logic [NUM_AXES-1:0][W_REM-1:0] rem_nx;
    logic [NUM_AXES-1:0][W_QUO-1:0] quo_nx;
    logic [W_LEN-1:0]               len_in;
    logic [SB_W-1:0]                sb_s;
    logic                           v_in;
    logic [W_REM-1:0]               dsh;

    if (i == 0) begin : g_first
      // numerator is mag * 2^16 plus half the divisor for rounding
      for (genvar k = 0; k < NUM_AXES; k++) begin : g_num
        assign rem_in[k] = ({{(W_REM-W_MAG){1'b0}}, mag[k]} << FRAC)
                         + W_REM'(len >> 1);
      end
      assign quo_in = '0;
      assign len_in = len;
      assign sb_s   = sb_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign len_in = len_r[i-1];
      assign sb_s   = sb_r[i-1];
      assign v_in   = vld_r[i-1];
    end

    assign dsh = {{(W_REM-W_LEN){1'b0}}, len_in} << B;

    always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (rem_in[k] >= dsh) begin
          rem_nx[k] = rem_in[k] - dsh;
          quo_nx[k] = quo_in[k] | (W_QUO'(1) << B);
        end else begin
          rem_nx[k] = rem_in[k];
          quo_nx[k] = quo_in[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nx;
        quo_r[i] <= quo_nx;
        len_r[i] <= len_in;
        sb_r[i]  <= sb_s;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end
  end

  assign out_valid = vld_r[W_QUO-1];
  assign quo       = quo_r[W_QUO-1];
  assign sb_out    = sb_r[W_QUO-1];

endmodule

FILE: rtl/lookat_norm.sv
module lookat_norm #(
  parameter int IN_W = 33,
  parameter int SB_W = 1
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic                                                     en,
  input  logic                                                     in_valid,
  input  logic [lookat_pkg::NUM_AXES-1:0][IN_W-1:0]               vec,
  input  logic [SB_W-1:0]                                         sb_in,
  output logic                                                     out_valid,
  output logic [lookat_pkg::NUM_AXES-1:0][lookat_pkg::W_UNIT-1:0] unit,
  output logic [SB_W-1:0]                                         sb_out
);
  import lookat_pkg::*;

  localparam int SH_W  = $clog2(IN_W);
  localparam int SQ_SB = SB_W + 2 * NUM_AXES / NUM_AXES * NUM_AXES / 2 + NUM_AXES * W_MAG + 1;
  localparam int DV_SB = SB_W + NUM_AXES + 1;

  // stage 1: sign and magnitude
  logic [NUM_AXES-1:0][IN_W-1:0] s1_mag;
  logic [NUM_AXES-1:0]           s1_neg;
  logic [SB_W-1:0]               s1_sb;
  logic                          s1_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s1_neg[k] <= vec[k][IN_W-1];
        s1_mag[k] <= vec[k][IN_W-1] ? IN_W'(~vec[k] + IN_W'(1)) : vec[k];
      end
      s1_sb <= sb_in;
    end
  end

  // stage 2: largest magnitude
  logic [NUM_AXES-1:0][IN_W-1:0] s2_mag;
  logic [NUM_AXES-1:0]           s2_neg;
  logic [IN_W-1:0]               s2_max;
  logic [SB_W-1:0]               s2_sb;
  logic                          s2_valid;
  logic [IN_W-1:0]               max_01;

  assign max_01 = (s1_mag[1] > s1_mag[0]) ? s1_mag[1] : s1_mag[0];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
      s2_max <= (s1_mag[2] > max_01) ? s1_mag[2] : max_01;
      s2_sb  <= s1_sb;
    end
  end

  // stage 3: leading one and block-scale shift
  logic [NUM_AXES-1:0][IN_W-1:0] s3_mag;
  logic [NUM_AXES-1:0]           s3_neg;
  logic                          s3_right;
  logic [SH_W-1:0]               s3_amt;
  logic                          s3_zero;
  logic [SB_W-1:0]               s3_sb;
  logic                          s3_valid;
  logic [SH_W-1:0]               lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (s2_max[i]) lead = SH_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag   <= s2_mag;
      s3_neg   <= s2_neg;
      s3_right <= lead >= SH_W'(SCALE_MSB);
      s3_amt   <= (lead >= SH_W'(SCALE_MSB)) ? lead - SH_W'(SCALE_MSB)
                                               : SH_W'(SCALE_MSB) - lead;
      s3_zero  <= s2_max == '0;
      s3_sb    <= s2_sb;
    end
  end

  // stage 4: scaled magnitudes, the largest in [2^30, 2^31) unless all are zero
  logic [NUM_AXES-1:0][W_MAG-1:0] s4_w;
  logic [NUM_AXES-1:0]            s4_neg;
  logic                           s4_zero;
  logic [SB_W-1:0]                s4_sb;
  logic                           s4_valid;
  logic [NUM_AXES-1:0][IN_W-1:0]  shifted;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      shifted[k] = s3_right ? (s3_mag[k] >> s3_amt) : (s3_mag[k] << s3_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s4_w[k] <= shifted[k][W_MAG-1:0];
      end
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      s4_sb   <= s3_sb;
    end
  end

  // stage 5: squares
  logic [NUM_AXES-1:0][2*W_MAG-1:0] s5_sq;
  logic [NUM_AXES-1:0][W_MAG-1:0]   s5_w;
  logic [NUM_AXES-1:0]              s5_neg;
  logic                             s5_zero;
  logic [SB_W-1:0]                  s5_sb;
  logic                             s5_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s5_sq[k] <= (2*W_MAG)'(s4_w[k]) * (2*W_MAG)'(s4_w[k]);
      end
      s5_w    <= s4_w;
      s5_neg  <= s4_neg;
      s5_zero <= s4_zero;
      s5_sb   <= s4_sb;
    end
  end

  // stage 6: squared length
  logic [W_RAD-1:0]               s6_len2;
  logic [NUM_AXES-1:0][W_MAG-1:0] s6_w;
  logic [NUM_AXES-1:0]            s6_neg;
  logic                           s6_zero;
  logic [SB_W-1:0]                s6_sb;
  logic                           s6_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_len2 <= W_RAD'(s5_sq[0]) + W_RAD'(s5_sq[1]) + W_RAD'(s5_sq[2]);
      s6_w    <= s5_w;
      s6_neg  <= s5_neg;
      s6_zero <= s5_zero;
      s6_sb   <= s5_sb;
    end
  end

  // valid bits for the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // length by square root
  logic                           sq_valid;
  logic [W_LEN-1:0]               sq_root;
  logic [SQ_SB-1:0]               sq_sb;
  logic [SB_W-1:0]                sq_user;
  logic [NUM_AXES-1:0]            sq_neg;
  logic [NUM_AXES-1:0][W_MAG-1:0] sq_w;
  logic                           sq_zero;

  lookat_sqrt #(.SB_W(SQ_SB)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_valid),
    .rad      (s6_len2),
    .sb_in    ({s6_sb, s6_neg, s6_w, s6_zero}),
    .out_valid(sq_valid),
    .root     (sq_root),
    .sb_out   (sq_sb)
  );

  assign {sq_user, sq_neg, sq_w, sq_zero} = sq_sb;

  // component over length
  logic                           dv_valid;
  logic [NUM_AXES-1:0][W_QUO-1:0] dv_quo;
  logic [DV_SB-1:0]               dv_sb;
  logic [SB_W-1:0]                dv_user;
  logic [NUM_AXES-1:0]            dv_neg;
  logic                           dv_zero;

  lookat_div #(.SB_W(DV_SB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .mag      (sq_w),
    .len      (sq_root),
    .sb_in    ({sq_user, sq_neg, sq_zero}),
    .out_valid(dv_valid),
    .quo      (dv_quo),
    .sb_out   (dv_sb)
  );

  assign {dv_user, dv_neg, dv_zero} = dv_sb;

  // final stage: clamp, sign and zero vector
  logic [NUM_AXES-1:0][W_UNIT-1:0] unit_r;
  logic [SB_W-1:0]                 sb_r;
  logic                            valid_r;
  logic signed [W_UNIT-1:0]        lim [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      lim[k] = clamp_unit($signed({{(W_RND-W_QUO){1'b0}}, dv_quo[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (dv_zero) begin
          unit_r[k] <= '0;
        end else begin
          unit_r[k] <= dv_neg[k] ? W_UNIT'(-lim[k]) : W_UNIT'(lim[k]);
        end
      end
      sb_r <= dv_user;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= dv_valid;
    end
  end

  assign out_valid = valid_r;
  assign unit      = unit_r;
  assign sb_out    = sb_r;

endmodule
